FILE: hdl/idsu_pkg.sv
// shared types and constants for the signed/unsigned integer divider
// no dependencies
`default_nettype none

package idsu_pkg;

    localparam int DIV_W = 32;
    localparam int KIND_W = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_UQUO = 2'd0,
        KIND_UREM = 2'd1,
        KIND_SQUO = 2'd2,
        KIND_SREM = 2'd3
    } kind_t;

    typedef struct packed {
        logic sel_rem;
        logic neg_q;
        logic neg_r;
        logic den_zero;
    } ctrl_t;

    typedef struct packed {
        ctrl_t            ctrl;
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] nq;
        logic [DIV_W-1:0] den;
    } stage_t;

endpackage

`default_nettype wire

FILE: hdl/idsu_pre.sv
// input cell: operand magnitudes and sign/select control for the divider
// depends on idsu_pkg
`default_nettype none

module idsu_pre (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      in_valid,
    output logic                     in_ready,
    input  wire  [idsu_pkg::KIND_W-1:0] kind,
    input  wire  [idsu_pkg::DIV_W-1:0]  dividend,
    input  wire  [idsu_pkg::DIV_W-1:0]  divisor,
    output logic                     out_valid,
    input  wire                      out_ready,
    output idsu_pkg::stage_t         out_data
);
    import idsu_pkg::*;

    logic   valid_reg;
    stage_t data_reg;
    stage_t data_next;
    logic   is_signed;
    logic   sa;
    logic   sb;

    always_comb
    begin
        is_signed = (kind == KIND_SQUO) || (kind == KIND_SREM);
        sa = is_signed & dividend[DIV_W-1];
        sb = is_signed & divisor[DIV_W-1];
        data_next.ctrl.sel_rem  = (kind == KIND_UREM) || (kind == KIND_SREM);
        data_next.ctrl.neg_q    = sa ^ sb;
        data_next.ctrl.neg_r    = sa;
        data_next.ctrl.den_zero = (divisor == '0);
        data_next.rem = '0;
        data_next.nq  = sa ? (~dividend + 1'b1) : dividend;
        data_next.den = sb ? (~divisor + 1'b1) : divisor;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/idsu_cell.sv
// one restoring division step: shift in a dividend bit, trial subtract, one quotient bit
// depends on idsu_pkg
`default_nettype none

module idsu_cell (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  wire idsu_pkg::stage_t in_data,
    output logic                  out_valid,
    input  wire                   out_ready,
    output idsu_pkg::stage_t      out_data
);
    import idsu_pkg::*;

    logic           valid_reg;
    stage_t         data_reg;
    stage_t         data_next;
    logic [DIV_W:0] r_sh;
    logic [DIV_W:0] diff;
    logic           ge;

    always_comb
    begin
        r_sh = {in_data.rem, in_data.nq[DIV_W-1]};
        diff = r_sh - {1'b0, in_data.den};
        ge   = !diff[DIV_W];
        data_next      = in_data;
        data_next.rem  = ge ? diff[DIV_W-1:0] : r_sh[DIV_W-1:0];
        data_next.nq   = {in_data.nq[DIV_W-2:0], ge};
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/idsu_post.sv
// output cell: sign fix-up, quotient/remainder select and zero-divisor override
// depends on idsu_pkg
`default_nettype none

module idsu_post (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        in_valid,
    output logic                       in_ready,
    input  wire idsu_pkg::stage_t      in_data,
    output logic                       out_valid,
    input  wire                        out_ready,
    output logic [idsu_pkg::DIV_W-1:0] answer,
    output logic                       divisor_zero
);
    import idsu_pkg::*;

    logic             valid_reg;
    logic [DIV_W-1:0] answer_reg;
    logic [DIV_W-1:0] answer_next;
    logic             zero_reg;
    logic [DIV_W-1:0] mag;
    logic             neg;

    always_comb
    begin
        mag = in_data.ctrl.sel_rem ? in_data.rem : in_data.nq;
        neg = in_data.ctrl.sel_rem ? in_data.ctrl.neg_r : in_data.ctrl.neg_q;
        if (in_data.ctrl.den_zero)
        begin
            answer_next = '0;
        end
        else
        begin
            answer_next = neg ? (~mag + 1'b1) : mag;
        end
    end

    assign in_ready     = !valid_reg || out_ready;
    assign out_valid    = valid_reg;
    assign answer       = answer_reg;
    assign divisor_zero = zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            answer_reg <= answer_next;
            zero_reg   <= in_data.ctrl.den_zero;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/int_divider_signed_unsigned_unit.sv
// top level of the pipelined signed/unsigned integer divider
// depends on idsu_pkg, idsu_pre, idsu_cell, idsu_post
//
//  channel  dir  tdata                          tuser
//  s_*      in   [31:0] dividend [63:32] divisor [1:0] kind
//  m_*      out  [31:0] answer                   [0] divisor_zero
//
// one request per cycle sustained while the output is not stalled; input cell, 32 step cells, output cell
// every cell holds its own valid and moves when the next cell is empty or moving
// a stalled output still lets requests fill empty cells behind it
// reset clears the valid bits only
`default_nettype none

module int_divider_signed_unsigned_unit (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [63:0] s_tdata,   // dividend, divisor
    input  wire  [1:0]  s_tuser,   // kind
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // answer
    output logic [0:0]  m_tuser    // divisor_zero
);
    import idsu_pkg::*;

    stage_t           chain_data  [DIV_W+1];
    logic [DIV_W:0]   chain_valid;
    logic [DIV_W+1:1] chain_ready;
    logic             zero_flag;

    idsu_pre u_pre (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .kind      (s_tuser),
        .dividend  (s_tdata[DIV_W-1:0]),
        .divisor   (s_tdata[2*DIV_W-1:DIV_W]),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[1]),
        .out_data  (chain_data[0])
    );

    for (genvar i = 0; i < DIV_W; i++)
    begin : g_cell
        idsu_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i+1]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+2]),
            .out_data  (chain_data[i+1])
        );
    end

    idsu_post u_post (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (chain_valid[DIV_W]),
        .in_ready     (chain_ready[DIV_W+1]),
        .in_data      (chain_data[DIV_W]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .answer       (m_tdata),
        .divisor_zero (zero_flag)
    );

    assign m_tuser = zero_flag;

    a_zero_answer : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("zero divisor result not forced to zero");

    a_accept_fills : assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> chain_valid[0])
        else $error("accepted request lost at input cell");

    a_tail_holds : assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[DIV_W] && !chain_ready[DIV_W+1] |=> chain_valid[DIV_W])
        else $error("last step cell dropped a stalled request");

    a_stall_blocks : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready && chain_valid[DIV_W] |-> !chain_ready[DIV_W+1])
        else $error("output cell accepted while full and stalled");

endmodule

`default_nettype wire

FILE: tb/divider_checker.sv
// request/result checker for int_divider_signed_unsigned_unit: predicts each answer and compares
// depends on idsu_pkg
`default_nettype none

module divider_checker (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire  [63:0] s_tdata,   // dividend, divisor
    input  wire  [1:0]  s_tuser,   // kind
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire  [31:0] m_tdata,   // answer
    input  wire  [0:0]  m_tuser,   // divisor_zero
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import idsu_pkg::*;

    typedef struct {
        logic [DIV_W-1:0] answer;
        logic             divisor_zero;
    } div_result_t;

    div_result_t expected_answers[$];
    int          errors = 0;

    function automatic div_result_t divide_result(kind_t op, logic [DIV_W-1:0] num,
                                                  logic [DIV_W-1:0] den);
        div_result_t      res;
        logic [DIV_W-1:0] num_mag;
        logic [DIV_W-1:0] den_mag;
        logic [DIV_W-1:0] quo;
        logic [DIV_W-1:0] rem;
        logic             num_neg;
        logic             den_neg;
        res.answer = '0;
        res.divisor_zero = (den == '0);
        if (res.divisor_zero)
        begin
            return res;
        end
        num_neg = num[DIV_W-1];
        den_neg = den[DIV_W-1];
        case (op)
            KIND_UQUO: res.answer = num / den;
            KIND_UREM: res.answer = num % den;
            default:
            begin
                // magnitudes fit unsigned, so the most negative value stays exact
                num_mag = num_neg ? -num : num;
                den_mag = den_neg ? -den : den;
                quo = num_mag / den_mag;
                rem = num_mag % den_mag;
                if (op == KIND_SQUO)
                begin
                    res.answer = (num_neg ^ den_neg) ? -quo : quo;
                end
                else
                begin
                    res.answer = num_neg ? -rem : rem;
                end
            end
        endcase
        return res;
    endfunction

    task automatic note_failure(string msg);
        errors++;
        if (errors <= 10)
        begin
            $display("[%0t] %s", $realtime, msg);
        end
    endtask

    always @(posedge clk)
    begin
        div_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_answers.size() == 0)
                begin
                    note_failure($sformatf("result with no request: answer %h zero %b",
                                           m_tdata, m_tuser[0]));
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (m_tdata !== want.answer || m_tuser[0] !== want.divisor_zero)
                    begin
                        note_failure($sformatf(
                            "mismatch: answer exp %h got %h, divisor_zero exp %b got %b",
                            want.answer, m_tdata, want.divisor_zero, m_tuser[0]));
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                expected_answers.push_back(divide_result(kind_t'(s_tuser),
                                                         s_tdata[31:0], s_tdata[63:32]));
            end
        end
        pending <= expected_answers.size();
        fail_count <= errors;
    end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// stimulus and verdict for int_divider_signed_unsigned_unit
// depends on idsu_pkg, divider_checker and the divider rtl
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import idsu_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;   // dividend, divisor
    logic [1:0]  s_tuser = '0;   // kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // answer
    logic [0:0]  m_tuser;        // divisor_zero

    int fail_count;
    int pending;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_count = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    int_divider_signed_unsigned_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    divider_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // receiver backpressure, switching between patterns
    always @(posedge clk)
    begin
        if (stall_count == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_count <= $urandom_range(50, 300);
        end
        else
        begin
            stall_count <= stall_count - 1;
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (stall_count % 4) == 0;
            default: m_tready <= (stall_count % 40) < 10;
        endcase
    end

    task automatic send_request(kind_t op, logic [31:0] num, logic [31:0] den);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {den, num};
        s_tuser <= op;
        do
            @(posedge clk);
        while (!s_tready);
        burst_left--;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        burst_left = $urandom_range(1, 20);
    endtask

    function automatic logic [31:0] pick_operand();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            4: v = $urandom_range(0, 15);
            5: v = -$urandom_range(1, 16);
            6:
            begin
                case ($urandom_range(0, 4))
                    0: v = 32'h0000_0000;
                    1: v = 32'h0000_0001;
                    2: v = 32'h7fff_ffff;
                    3: v = 32'h8000_0000;
                    default: v = 32'hffff_ffff;
                endcase
            end
            7: v = $urandom >> $urandom_range(0, 31);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    logic [31:0] edge_num[6] = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000,
                                 32'hffff_fff9, 32'h0000_0007, 32'h7fff_ffff};
    logic [31:0] edge_den[6] = '{32'h0000_0000, 32'h0000_0001, 32'hffff_ffff,
                                 32'h0000_0002, 32'hffff_fffe, 32'h8000_0000};

    initial
    begin
        logic [31:0] num;
        logic [31:0] den;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero divisor, min by minus one, mixed signs, all-ones operands
        for (int k = 0; k < 4; k++)
        begin
            for (int p = 0; p < 6; p++)
            begin
                send_request(kind_t'(k), edge_num[p], edge_den[p]);
            end
        end
        wait_drained();

        for (int i = 0; i < 850; i++)
        begin
            num = pick_operand();
            den = ($urandom_range(0, 99) < 4) ? 32'h0 : pick_operand();
            send_request(kind_t'($urandom_range(0, 3)), num, den);
            if (i == 425)
            begin
                wait_drained();
            end
        end
        wait_drained();
        repeat (40) @(posedge clk);

        if (fail_count == 0 && pending == 0)
        begin
            $display("int_divider_signed_unsigned_unit test passed");
        end
        else
        begin
            $display("int_divider_signed_unsigned_unit test failed");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("int_divider_signed_unsigned_unit test failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
hdl/idsu_pkg.sv
hdl/idsu_pre.sv
hdl/idsu_cell.sv
hdl/idsu_post.sv
hdl/int_divider_signed_unsigned_unit.sv
tb/divider_checker.sv
tb/tb_top.sv
